### rtl/sitoa_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sitoa_pkg;

    // Field widths.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;

    // A 32-bit magnitude has at most ten decimal digits.
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_IDX_W = 4;

    // Character codes, truncated to the six bits of the text port.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Division by ten as a multiply by a scaled reciprocal and a right shift.
    // The pair is exact for every 32-bit unsigned dividend.
    localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT = 35;

    // Default depth of the job queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified job: the sign and the unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } sitoa_job_t;

endpackage

### rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal text converter.
//
//   Channel   Direction   Handshake                  Word
//   value     input       value_valid / value_ready  value[31:0], signed
//   text      output      text_valid / text_ready    text_char[5:0], is_last
//
// The back part takes a job, peels its digits, then sends an optional minus
// sign and the digits most significant first. The digit loop divides by ten
// with one 32x32 multiply per cycle; the one-word text channel then sends a
// character per cycle while the receiver holds text_ready high.
// Reset clears the queue and the sequencer; no state is kept between numbers.
// The input side keeps taking numbers while the queue has room, even when the
// text side stalls.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii
    import sitoa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      value_valid,
    output logic                      value_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      text_valid,
    input  logic                      text_ready,
    output logic [CHAR_W-1:0]         text_char,
    output logic                      is_last
);

    logic       queue_full;
    logic       queue_push;
    logic       queue_pop;
    logic       queue_not_empty;
    sitoa_job_t push_job;
    sitoa_job_t head_job;

    sitoa_front u_front (
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .queue_full  (queue_full),
        .queue_push  (queue_push),
        .queue_data  (push_job)
    );

    sitoa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (head_job),
        .not_empty (queue_not_empty)
    );

    sitoa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (queue_not_empty),
        .job        (head_job),
        .job_pop    (queue_pop),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_char  (text_char),
        .is_last    (is_last)
    );

endmodule

### rtl/sitoa_front.sv
// Front part: accepts input words and splits them into sign and magnitude.
`timescale 1ns / 1ps

module sitoa_front
    import sitoa_pkg::*;
(
    input  logic                      value_valid,
    output logic                      value_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      queue_full,
    output logic                      queue_push,
    output sitoa_job_t                queue_data
);

    logic               neg;
    logic [VALUE_W-1:0] raw;

    // A word is taken whenever the queue has room.
    assign value_ready = !queue_full;
    assign queue_push  = value_valid && !queue_full;

    // The magnitude is formed in unsigned arithmetic, so the most negative
    // value maps to 2^31 without overflow.
    assign raw = $unsigned(value);
    assign neg = raw[VALUE_W-1];

    always_comb
    begin
        queue_data.neg = neg;
        queue_data.mag = neg ? (VALUE_W'(0) - raw) : raw;
    end

endmodule

### rtl/sitoa_fifo.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps

module sitoa_fifo
    import sitoa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sitoa_job_t push_data,
    output logic       full,
    input  logic       pop,
    output sitoa_job_t pop_data,
    output logic       not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    sitoa_job_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/sitoa_back.sv
// Back part: converts one magnitude to digits and emits the text word by word.
`timescale 1ns / 1ps

module sitoa_back
    import sitoa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  sitoa_job_t        job,
    output logic              job_pop,
    output logic              text_valid,
    input  logic              text_ready,
    output logic [CHAR_W-1:0] text_char,
    output logic              is_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int PROD_W = 2 * VALUE_W;
    localparam int QUOT_W = PROD_W - DIV10_SHIFT;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [DIGIT_IDX_W-1:0] cnt_reg, cnt_next;
    logic [DIGIT_IDX_W-1:0] ptr_reg, ptr_next;
    logic [3:0]             digit_reg [NUM_DIGITS];

    logic                   text_valid_reg, text_valid_next;
    logic [CHAR_W-1:0]      text_char_reg, text_char_next;
    logic                   is_last_reg, is_last_next;

    logic [PROD_W-1:0]      prod;
    logic [QUOT_W-1:0]      quot;
    logic [3:0]             rem;
    logic                   digit_we;
    logic                   out_free;

    // Divide by ten through the reciprocal; the remainder needs only the low
    // four bits of mag - 10 * quot, since it always lies in 0..9.
    assign prod = PROD_W'(mag_reg) * PROD_W'(DIV10_RECIP);
    assign quot = prod[PROD_W-1:DIV10_SHIFT];
    assign rem  = mag_reg[3:0] - ({quot[2:0], 1'b0} + {quot[0], 3'b000});

    // The output register can load when empty or when its word leaves now.
    assign out_free = !text_valid_reg || text_ready;

    assign text_valid = text_valid_reg;
    assign text_char  = text_char_reg;
    assign is_last    = is_last_reg;

    // Sequencer: take a job, peel digits least significant first, then send the
    // minus sign for a negative job and read the digits back most significant first.
    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        job_pop         = 1'b0;
        digit_we        = 1'b0;
        text_valid_next = text_valid_reg && !text_ready;
        text_char_next  = text_char_reg;
        is_last_next    = is_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    mag_next   = job.mag;
                    neg_next   = job.neg;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                digit_we = 1'b1;
                mag_next = VALUE_W'(quot);
                cnt_next = cnt_reg + 1'b1;
                if (quot == '0)
                begin
                    ptr_next   = cnt_reg;
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    text_valid_next = 1'b1;
                    text_char_next  = CHAR_MINUS;
                    is_last_next    = 1'b0;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    text_valid_next = 1'b1;
                    text_char_next  = CHAR_ZERO + {2'b00, digit_reg[ptr_reg]};
                    is_last_next    = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            text_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            text_valid_reg <= text_valid_next;
        end
    end

    // Working registers and the digit buffer carry payload only.
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        ptr_reg       <= ptr_next;
        text_char_reg <= text_char_next;
        is_last_reg   <= is_last_next;
        if (digit_we)
        begin
            digit_reg[cnt_reg] <= rem;
        end
    end

endmodule

### rtl/sitoa_checker.sv
// Port-level checks on the text output of the converter, with their bind.
`timescale 1ns / 1ps

module sitoa_checker
    import sitoa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              text_valid,
    input logic              text_ready,
    input logic [CHAR_W-1:0] text_char,
    input logic              is_last
);

    logic mid_reg;
    logic after_minus_reg;
    logic text_take;
    logic first_digit;

    assign text_take   = text_valid && text_ready;
    assign first_digit = !mid_reg || after_minus_reg;

    // Track where in a number the next word falls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg         <= 1'b0;
            after_minus_reg <= 1'b0;
        end
        else if (text_take)
        begin
            mid_reg         <= !is_last;
            after_minus_reg <= (text_char == CHAR_MINUS);
        end
    end

    // A stalled word holds its character and flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(text_char) && $stable(is_last))
        else $error("text word changed while stalled");

    // Only a minus sign or a decimal digit ever leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> (text_char == CHAR_MINUS) ||
                       (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 6'd9))
        else $error("character outside the decimal text set");

    // A minus sign opens a number and is never its end.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_char == CHAR_MINUS |-> !mid_reg && !is_last)
        else $error("minus sign out of place");

    // A leading zero is only allowed as the whole text of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && first_digit && text_char == CHAR_ZERO |-> is_last && !after_minus_reg)
        else $error("leading zero or negative zero");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_char  (text_char),
    .is_last    (is_last)
);

### tb/sv/decimal_text_checker.sv
// Checker that predicts the decimal text of each accepted value and compares the text words.
`timescale 1ns / 1ps

module decimal_text_checker
    import sitoa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      value_valid,
    input  logic                      value_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      text_valid,
    input  logic                      text_ready,
    input  logic [CHAR_W-1:0]         text_char,
    input  logic                      is_last,
    output int                        fail_count,
    output int                        chars_outstanding
);

    // One expected text word.
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_word_t;

    text_word_t expected_chars[$];

    initial
    begin
        fail_count        = 0;
        chars_outstanding = 0;
    end

    // Build the characters of one number, most significant first, and queue them.
    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] raw);
        logic              neg;
        logic [VALUE_W-1:0] mag;
        logic [3:0]        digits [NUM_DIGITS];
        int                nd;
        text_word_t        w;
        neg = raw[VALUE_W-1];
        // The magnitude is taken modulo 2^32, so the most negative value stays exact.
        mag = neg ? (32'd0 - raw) : raw;
        for (nd = 0; nd == 0 || mag != 0; nd++)
        begin
            digits[nd] = 4'(mag % 32'd10);
            mag        = mag / 32'd10;
        end
        if (neg)
        begin
            w.code = CHAR_MINUS;
            w.last = 1'b0;
            expected_chars.push_back(w);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            w.code = CHAR_ZERO + CHAR_W'(digits[i]);
            w.last = (i == 0);
            expected_chars.push_back(w);
        end
    endfunction

    // Compare each accepted text word with the oldest expectation, then predict new input.
    always @(posedge clk)
    begin
        text_word_t exp_w;
        if (rst_n)
        begin
            if (text_valid && text_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected text word: expected none, actual char=%0d last=%0b",
                             $time, text_char, is_last);
                end
                else
                begin
                    exp_w = expected_chars.pop_front();
                    if (text_char !== exp_w.code || is_last !== exp_w.last)
                    begin
                        fail_count++;
                        $display("%0t: text mismatch: expected char=%0d last=%0b, actual char=%0d last=%0b",
                                 $time, exp_w.code, exp_w.last, text_char, is_last);
                    end
                end
            end
            if (value_valid && value_ready)
            begin
                predict_decimal_text(value);
            end
            chars_outstanding = expected_chars.size();
        end
    end

endmodule

### tb/sv/tb_signed_int_to_decimal_ascii.sv
// Testbench top for the signed integer to decimal text converter: stimulus, flow control, verdict.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii
    import sitoa_pkg::*;
;

    localparam int  CLK_HALF_NS   = 6;
    localparam int  RESET_CYCLES  = 10;
    localparam int  STALL_CYCLES  = 150;
    localparam int  DRAIN_CYCLES  = 40;
    localparam int  PHASE_ITEMS   = 53;
    localparam time TIMEOUT_NS    = 200_000 * 12;

    logic                      clk;
    logic                      rst_n;
    logic                      value_valid;
    logic                      value_ready;
    logic signed [VALUE_W-1:0] value;
    logic                      text_valid;
    logic                      text_ready;
    logic [CHAR_W-1:0]         text_char;
    logic                      is_last;

    int fail_count;
    int chars_outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    bit stall_request;

    signed_int_to_decimal_ascii dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_char   (text_char),
        .is_last     (is_last)
    );

    decimal_text_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .value_valid       (value_valid),
        .value_ready       (value_ready),
        .value             (value),
        .text_valid        (text_valid),
        .text_ready        (text_ready),
        .text_char         (text_char),
        .is_last           (is_last),
        .fail_count        (fail_count),
        .chars_outstanding (chars_outstanding)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Hard limit on the run.
    initial
    begin
        #TIMEOUT_NS;
        $display("tb_signed_int_to_decimal_ascii NOT OK");
        $finish;
    end

    // Receiver: random back-pressure, with an occasional long hold-off on request.
    initial
    begin
        text_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                text_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                text_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one value word; returns just after the falling edge following acceptance.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            @(negedge clk);
        end
        value_valid <= 1'b1;
        value       <= v;
        @(posedge clk);
        while (!value_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Random value: full range, small magnitudes, values below 10^8, or near powers of ten, either sign.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 999);
            2:
            begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                v = p + $urandom_range(0, 2) - 32'd1;
            end
            default: v = $urandom_range(0, 99_999_999);
        endcase
        if (v[VALUE_W-1] == 1'b0 && $urandom_range(0, 1))
        begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        logic [VALUE_W-1:0] directed [$];
        rst_n         = 1'b0;
        value_valid   = 1'b0;
        value         = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b0;
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                     32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'd1_000_000_000, 32'd999_999_999, 32'hC465_3601,
                     32'd1_234_567_890, 32'hB669_FD2E, 32'd42, 32'hFFFF_FFFB,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'd4_000_000_000};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: light sender gaps, heavy receiver back-pressure.
        send_idle_pct = 13;
        recv_idle_pct = 59;

        // Directed words: extremes, sign boundaries, digit-count boundaries.
        foreach (directed[i])
        begin
            send_value(directed[i]);
        end

        repeat (PHASE_ITEMS) send_value(random_value());

        // Sender waits until all text has come out.
        value_valid <= 1'b0;
        wait (chars_outstanding == 0);
        @(negedge clk);

        // Phase two: long receiver hold-off first, so the block fills and blocks its input.
        send_idle_pct = 59;
        recv_idle_pct = 13;
        stall_request = 1'b1;
        repeat (PHASE_ITEMS) send_value(random_value());

        // Phase three: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) send_value(random_value());

        // Drain and give the verdict.
        value_valid <= 1'b0;
        wait (chars_outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_signed_int_to_decimal_ascii OK");
        end
        else
        begin
            $display("tb_signed_int_to_decimal_ascii NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/sitoa_pkg.sv
rtl/sitoa_front.sv
rtl/sitoa_fifo.sv
rtl/sitoa_back.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sitoa_checker.sv
tb/sv/decimal_text_checker.sv
tb/sv/tb_signed_int_to_decimal_ascii.sv
